[sv/dtsf_pkg.sv]
// ----------------------------------------------------------------------------
// dtsf_pkg
// shared types, constants and register codes of the dual-tap sawtooth flanger
// ----------------------------------------------------------------------------
package dtsf_pkg;

    localparam int DELAY_LENGTH_DEF = 1024;
    localparam int CHANNELS_DEF     = 2;

    localparam int SAMPLE_W   = 24;
    localparam int DEPTH_W    = 18;
    localparam int PHASE_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // register codes
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREDELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND = 3'd4;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 24'd35;
    localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd16384;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PHASE,
        ST_DELAY,
        ST_POS,
        ST_WRAP,
        ST_RD0,
        ST_RD1,
        ST_INTERP,
        ST_MAC,
        ST_COMMIT
    } dtsf_state_t;

    typedef struct packed {
        logic clear;
        logic load_in;
        logic phase;
        logic delay;
        logic pos;
        logic wrap;
        logic rd_first;
        logic rd_second;
        logic interp;
        logic mac;
        logic commit;
    } dtsf_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic wrap_last;
        logic tap_second;
        logic out_free;
    } dtsf_status_t;

endpackage

[sv/dtsf_ctrl.sv]
// ----------------------------------------------------------------------------
// dtsf_ctrl
// sequencer: clearing pass, then per item two tap passes and a commit step
// ----------------------------------------------------------------------------
module dtsf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  dtsf_pkg::dtsf_status_t status,
    output dtsf_pkg::dtsf_cmd_t    cmd
);
    import dtsf_pkg::*;

    dtsf_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_PHASE;
                end
            end
            ST_PHASE: begin
                cmd.phase  = 1'b1;
                state_next = ST_DELAY;
            end
            ST_DELAY: begin
                cmd.delay  = 1'b1;
                state_next = ST_POS;
            end
            ST_POS: begin
                cmd.pos    = 1'b1;
                state_next = ST_WRAP;
            end
            ST_WRAP: begin
                cmd.wrap = 1'b1;
                if (status.wrap_last) state_next = ST_RD0;
            end
            ST_RD0: begin
                cmd.rd_first = 1'b1;
                state_next   = ST_RD1;
            end
            ST_RD1: begin
                cmd.rd_second = 1'b1;
                state_next    = ST_INTERP;
            end
            ST_INTERP: begin
                cmd.interp = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                cmd.mac    = 1'b1;
                state_next = status.tap_second ? ST_COMMIT : ST_DELAY;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/dtsf_dpath.sv]
// ----------------------------------------------------------------------------
// dtsf_dpath
// lfo, tap delay, position wrap, delay memory, interpolation and mixing
// ----------------------------------------------------------------------------
module dtsf_dpath #(
    parameter int DELAY_LENGTH = dtsf_pkg::DELAY_LENGTH_DEF,
    parameter int CHANNELS     = dtsf_pkg::CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dtsf_pkg::dtsf_cmd_t                 cmd,
    output dtsf_pkg::dtsf_status_t              status,
    input  logic [dtsf_pkg::SAMPLE_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dtsf_pkg::SAMPLE_W-1:0]       m_tdata,
    output logic                                m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [dtsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dtsf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import dtsf_pkg::*;

    localparam longint M     = longint'(DELAY_LENGTH) * 256;
    localparam longint K     = (longint'(2) ** 19 + M - 1) / M;
    localparam longint QMAX  = K + 1 + (longint'(2) ** 18 + M - 1) / M;
    localparam int     QB    = $clog2(QMAX + 1);
    localparam int     RW    = $clog2(M) + QB;
    localparam int     SW    = $clog2(QB);
    localparam int     WPW   = $clog2(DELAY_LENGTH);
    localparam int     DEPTH = DELAY_LENGTH * CHANNELS;
    localparam int     AW    = $clog2(DEPTH);
    localparam int     CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [RW-1:0]  M_R   = RW'(M);
    localparam logic [RW-1:0]  OFF_R = RW'(M * K);
    localparam logic [WPW-1:0] WP_LAST = WPW'(DELAY_LENGTH - 1);
    localparam logic [AW-1:0]  CLR_LAST = AW'(DEPTH - 1);

    // configuration registers
    logic [DEPTH_W-1:0] depth_reg, predelay_reg;
    logic [PHASE_W-1:0] phase_step_reg;
    logic [GAIN_W-1:0]  gain_first_reg, gain_second_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg       <= '0;
            predelay_reg    <= '0;
            phase_step_reg  <= PHASE_STEP_RST;
            gain_first_reg  <= GAIN_RST;
            gain_second_reg <= GAIN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEPTH:       depth_reg       <= cfg_wdata[DEPTH_W-1:0];
                REG_PREDELAY:    predelay_reg    <= cfg_wdata[DEPTH_W-1:0];
                REG_PHASE_STEP:  phase_step_reg  <= cfg_wdata[PHASE_W-1:0];
                REG_GAIN_FIRST:  gain_first_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_SECOND: gain_second_reg <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // control state
    logic [PHASE_W-1:0] ft_reg;
    logic [WPW-1:0]     wp_reg [CHANNELS];
    logic [AW-1:0]      clr_cnt_reg;
    logic [SW-1:0]      step_reg;
    logic               tap_reg;
    logic               m_tvalid_reg;

    // payload
    logic signed [SAMPLE_W-1:0] x_reg, x0_reg, rdata_reg;
    logic                       chan_reg, fend_reg;
    logic [CW-1:0]              ch_reg;
    logic [PHASE_W-1:0]         p1_reg;
    logic signed [19:0]         dterm_reg;
    logic [RW-1:0]              r_reg;
    logic signed [33:0]         tapv_reg;
    logic signed [51:0]         acc_reg;
    logic [SAMPLE_W-1:0]        out_reg;
    logic                       out_chan_reg;

    logic [CW-1:0]  ch_in;
    logic [WPW-1:0] wp_cur;
    logic [AW-1:0]  base;
    logic [PHASE_W-1:0] p_sel;
    logic signed [24:0] saw;
    logic signed [43:0] dprod;
    logic signed [20:0] delay_q8;
    logic signed [RW+1:0] r_pre;
    logic [RW-1:0]  m_shift;
    logic [WPW-1:0] idx, nxt;
    logic [7:0]     frac;
    logic [AW-1:0]  rd_addr, wr_addr;
    logic           mem_we;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic signed [47:0] ptot;
    logic signed [28:0] y_full;

    assign ch_in  = (CHANNELS > 1) ? CW'(s_tuser) : '0;
    assign wp_cur = wp_reg[ch_reg];
    assign base   = AW'(ch_reg) * AW'(DELAY_LENGTH);

    // lfo phase and sawtooth of the current tap
    assign p_sel    = tap_reg ? (p1_reg + PHASE_W'(24'h800000)) : p1_reg;
    assign saw      = $signed({p_sel, 1'b0});
    assign dprod    = $signed({1'b0, depth_reg}) * saw;
    assign delay_q8 = $signed({3'b000, predelay_reg}) + 21'(dterm_reg);
    assign r_pre    = $signed({2'b00, RW'({wp_cur, 8'h00})}) + $signed({2'b00, OFF_R})
                      - (RW+2)'(delay_q8);
    assign m_shift  = M_R << step_reg;

    assign idx  = WPW'(r_reg >> 8);
    assign frac = r_reg[7:0];
    assign nxt  = (idx == WP_LAST) ? '0 : idx + 1'b1;

    // first read fetches the lower sample, then its neighbor
    always_comb begin
        rd_addr = base + AW'(nxt);
        if (cmd.rd_first) rd_addr = base + AW'(idx);
    end

    assign mem_we  = cmd.clear | cmd.commit;
    assign wr_addr = cmd.clear ? clr_cnt_reg : base + AW'(wp_cur);
    assign wr_data = cmd.clear ? '0 : x_reg;

    // delay memory
    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (mem_we) mem[wr_addr] <= wr_data;
        rdata_reg <= mem[rd_addr];
    end

    // weighted tap
    assign ptot = (tap_reg ? $signed({1'b0, gain_second_reg}) : $signed({1'b0, gain_first_reg}))
                  * tapv_reg;
    assign y_full = 29'((acc_reg + 52'sd4194304) >>> 23);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ft_reg       <= '0;
            clr_cnt_reg  <= '0;
            step_reg     <= '0;
            tap_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) wp_reg[i] <= '0;
        end else begin
            if (cmd.clear) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.load_in) tap_reg <= 1'b0;
            if (cmd.mac) tap_reg <= ~tap_reg;
            if (cmd.pos) step_reg <= SW'(QB - 1);
            if (cmd.wrap && step_reg != '0) step_reg <= step_reg - 1'b1;
            if (cmd.commit) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            if (cmd.commit) begin
                wp_reg[ch_reg] <= (wp_cur == WP_LAST) ? '0 : wp_cur + 1'b1;
                if (fend_reg) ft_reg <= ft_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg    <= $signed(s_tdata);
            chan_reg <= s_tuser;
            fend_reg <= s_tlast;
            ch_reg   <= ch_in;
            acc_reg  <= '0;
        end
        if (cmd.phase) p1_reg <= PHASE_W'(ft_reg * phase_step_reg);
        if (cmd.delay) dterm_reg <= 20'(dprod >>> 24);
        if (cmd.pos) r_reg <= RW'(r_pre);
        if (cmd.wrap && r_reg >= m_shift) r_reg <= r_reg - m_shift;
        if (cmd.rd_second) x0_reg <= rdata_reg;
        if (cmd.interp) begin
            tapv_reg <= 34'(x0_reg * $signed({1'b0, 9'(9'd256 - 9'(frac))}))
                      + 34'(rdata_reg * $signed({2'b00, frac}));
        end
        if (cmd.mac) acc_reg <= acc_reg + 52'(ptot);
        if (cmd.commit) begin
            if (y_full > 29'sd8388607) out_reg <= 24'h7FFFFF;
            else if (y_full < -29'sd8388608) out_reg <= 24'h800000;
            else out_reg <= y_full[SAMPLE_W-1:0];
            out_chan_reg <= chan_reg;
        end
    end

    assign status.clear_last = (clr_cnt_reg == CLR_LAST);
    assign status.wrap_last  = (step_reg == '0);
    assign status.tap_second = tap_reg;
    assign status.out_free   = ~m_tvalid_reg | m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign m_tuser  = out_chan_reg;

endmodule

[sv/dual_tap_sawtooth_flanger.sv]
// ----------------------------------------------------------------------------
// dual_tap_sawtooth_flanger
// two-tap barberpole flanger with a shared lfo and one delay line per channel
// ----------------------------------------------------------------------------
// sequencing: a new item is accepted only once the previous one is committed,
//   and the commit waits while the last result is still held at the output;
//   both tap passes of an item share one datapath and the delay memory
// reset: synchronous active-low; afterwards a clearing pass writes zero to all
//   DELAY_LENGTH*CHANNELS memory words, one per cycle, before the first item
// ----------------------------------------------------------------------------
module dual_tap_sawtooth_flanger #(
    parameter int DELAY_LENGTH = dtsf_pkg::DELAY_LENGTH_DEF,
    parameter int CHANNELS     = dtsf_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dtsf_pkg::SAMPLE_W-1:0]   s_tdata,   // [23:0] sample_in
    input  logic                            s_tuser,   // [0] chan
    input  logic                            s_tlast,   // frame_end
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dtsf_pkg::SAMPLE_W-1:0]   m_tdata,   // [23:0] sample_out
    output logic                            m_tuser,   // [0] chan_out
    // register writes
    input  logic                            cfg_wr_en,
    input  logic [dtsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtsf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import dtsf_pkg::*;

    dtsf_cmd_t    cmd;
    dtsf_status_t status;

    // sequencer: clearing pass, accept, two tap passes, commit
    dtsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, delay memory and output register
    dtsf_dpath #(
        .DELAY_LENGTH (DELAY_LENGTH),
        .CHANNELS     (CHANNELS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // commit never overwrites a result still waiting
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> status.out_free)
        else $error("commit while output busy");

    // an accepted item starts the phase step next
    a_accept_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cmd.phase)
        else $error("accept not followed by phase step");

    // a new result only appears after a commit
    a_valid_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result without commit");

endmodule

[test/flanger_checker.sv]
// ----------------------------------------------------------------------------
// flanger_checker
// watches both item channels and the register port of the flanger, predicts
// every result from its own copy of the delay lines, lfo and registers, and
// counts mismatches against the oldest predicted result
// ----------------------------------------------------------------------------
module flanger_checker #(
    parameter int DELAY_LENGTH = dtsf_pkg::DELAY_LENGTH_DEF,
    parameter int CHANNELS     = dtsf_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [dtsf_pkg::SAMPLE_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [dtsf_pkg::SAMPLE_W-1:0]   m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [dtsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dtsf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              pending
);
    import dtsf_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                chan;
    } flanged_t;

    flanged_t                   flanged_q[$];
    logic signed [SAMPLE_W-1:0] line_mem[DELAY_LENGTH*CHANNELS];
    int unsigned                wr_pos[CHANNELS];
    logic [31:0]                frame_cnt;
    logic [DEPTH_W-1:0]         depth_r, predelay_r;
    logic [PHASE_W-1:0]         step_r;
    logic [GAIN_W-1:0]          gain1_r, gain2_r;

    assign pending = flanged_q.size();

    // tap delay in q.8 samples for one lfo phase
    function automatic longint sweep_delay(logic [PHASE_W-1:0] ph);
        longint saw, prod;
        saw  = 2 * longint'(ph);
        if (ph[PHASE_W-1]) saw -= 2 * (longint'(1) << PHASE_W);
        prod = longint'(depth_r) * saw + (longint'(depth_r) << PHASE_W);
        return longint'(predelay_r) + (prod >>> PHASE_W) - longint'(depth_r);
    endfunction

    // interpolated tap, scaled by 2^8
    function automatic longint tap_read(int unsigned base, int unsigned wp, longint dly);
        longint span, r, f;
        int unsigned idx, nxt;
        span = longint'(DELAY_LENGTH) * 256;
        r    = (longint'(wp) * 256 - dly) % span;
        if (r < 0) r += span;
        idx  = int'(r >> 8);
        f    = r & 255;
        nxt  = (idx + 1 == DELAY_LENGTH) ? 0 : idx + 1;
        return longint'(line_mem[base + idx]) * (256 - f) + longint'(line_mem[base + nxt]) * f;
    endfunction

    function automatic logic [SAMPLE_W-1:0] flange(logic signed [SAMPLE_W-1:0] x,
                                                    logic ch_in);
        logic [PHASE_W-1:0] p1, p2;
        longint t1, t2, acc, y;
        int unsigned ch, base, wp;
        ch   = ch_in % CHANNELS;
        base = ch * DELAY_LENGTH;
        wp   = wr_pos[ch];
        p1   = PHASE_W'(frame_cnt * step_r);
        p2   = p1 + PHASE_W'(1 << (PHASE_W-1));
        t1   = tap_read(base, wp, sweep_delay(p1));
        t2   = tap_read(base, wp, sweep_delay(p2));
        line_mem[base + wp] = x;
        wr_pos[ch] = (wp + 1) % DELAY_LENGTH;
        acc  = longint'(gain1_r) * t1 + longint'(gain2_r) * t2;
        y    = (acc + (longint'(1) << 22)) >>> 23;   // round half up
        if (y > 8388607) y = 8388607;
        if (y < -8388608) y = -8388608;
        return SAMPLE_W'(y);
    endfunction

    always @(posedge aclk) begin
        flanged_t got, want;
        if (!aresetn) begin
            flanged_q.delete();
            foreach (line_mem[i]) line_mem[i] = '0;
            foreach (wr_pos[i]) wr_pos[i] = 0;
            frame_cnt  = '0;
            depth_r    = '0;
            predelay_r = '0;
            step_r     = PHASE_STEP_RST;
            gain1_r    = GAIN_RST;
            gain2_r    = GAIN_RST;
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEPTH:       depth_r    = cfg_wdata[DEPTH_W-1:0];
                    REG_PREDELAY:    predelay_r = cfg_wdata[DEPTH_W-1:0];
                    REG_PHASE_STEP:  step_r     = cfg_wdata[PHASE_W-1:0];
                    REG_GAIN_FIRST:  gain1_r    = cfg_wdata[GAIN_W-1:0];
                    REG_GAIN_SECOND: gain2_r    = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.sample = m_tdata;
                got.chan   = m_tuser;
                if (flanged_q.size() == 0) begin
                    $error("unexpected result item sample_out=%0d", $signed(m_tdata));
                    fail_count++;
                end else begin
                    want = flanged_q.pop_front();
                    if (got.sample !== want.sample) begin
                        $error("sample_out expected %0d actual %0d",
                               $signed(want.sample), $signed(got.sample));
                        fail_count++;
                    end
                    if (got.chan !== want.chan) begin
                        $error("chan_out expected %0d actual %0d", want.chan, got.chan);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want.chan   = s_tuser;
                want.sample = flange(s_tdata, s_tuser);
                flanged_q.push_back(want);
                if (s_tlast) frame_cnt++;
            end
        end
    end

endmodule

[test/tb_dual_tap_sawtooth_flanger.sv]
// ----------------------------------------------------------------------------
// tb_dual_tap_sawtooth_flanger
// drives directed and random audio items through the flanger under several
// register settings and random idling on both sides; the checker beside the
// block predicts each result and reports the mismatch count
// ----------------------------------------------------------------------------
module tb_dual_tap_sawtooth_flanger;
    import dtsf_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0, s_tready;
    logic [SAMPLE_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 1'b0, s_tlast = 1'b0;
    logic                  m_tvalid, m_tready = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count, pending;

    // idle percentages per side, and the long receiver hold-off
    int send_idle_pct = 0, recv_idle_pct = 0;
    int hold_cycles   = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    dual_tap_sawtooth_flanger i_dut (.*);

    flanger_checker i_chk (.*);

    // receiver: random stall, or a counted hold-off so the block backs up
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for every predicted result, then let the block settle
    task automatic drain();
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
    endtask

    task automatic set_regs(int dep, int pre, int stp, int g1, int g2);
        drain();
        write_reg(REG_DEPTH, CFG_DATA_W'(dep));
        write_reg(REG_PREDELAY, CFG_DATA_W'(pre));
        write_reg(REG_PHASE_STEP, CFG_DATA_W'(stp));
        write_reg(REG_GAIN_FIRST, CFG_DATA_W'(g1));
        write_reg(REG_GAIN_SECOND, CFG_DATA_W'(g2));
    endtask

    // offer one item at the falling edge, hold it until accepted
    task automatic send_sample(logic [SAMPLE_W-1:0] smp, logic ch, logic fend);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= ch;
        s_tlast  <= fend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // stereo frames of random content; some samples at the extremes
    task automatic random_frames(int count);
        logic [SAMPLE_W-1:0] smp;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(5))
                0: smp = 24'h7FFFFF;
                1: smp = 24'h800000;
                default: smp = SAMPLE_W'($urandom);
            endcase
            send_sample(smp, k[0] ^ ($urandom_range(15) == 0), k[0] || ($urandom_range(9) == 0));
        end
    endtask

    initial begin
        #400000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, field extremes, both channels, frame marks
        send_sample(24'h7FFFFF, 1'b0, 1'b0);
        send_sample(24'h800000, 1'b1, 1'b1);
        send_sample(24'h000000, 1'b0, 1'b0);
        send_sample(24'hFFFFFF, 1'b1, 1'b1);
        send_sample(24'h555555, 1'b0, 1'b1);
        send_sample(24'hAAAAAA, 1'b1, 1'b0);
        // full gains and deep sweep: saturation and line wrap
        set_regs(261888, 261888, 24'h800000, 32768, 32768);
        for (int k = 0; k < 8; k++) send_sample(k[0] ? 24'h7FFFFF : 24'h800000, k[1], 1'b1);
        // register tops beyond range, delays past the line length
        set_regs(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < 6; k++) send_sample(SAMPLE_W'($urandom), k[0], k[0]);
        // zero everything, and an unknown register index
        set_regs(0, 0, 0, 0, 0);
        write_reg(3'd7, 24'hFFFFFF);
        send_sample(24'h7FFFFF, 1'b0, 1'b1);
        send_sample(24'h800000, 1'b1, 1'b1);

        // random: receiver idles more first
        set_regs(2560, 1280, 1000, 16384, 16384);
        send_sample(24'h400000, 1'b0, 1'b1);
        send_idle_pct = 34; recv_idle_pct = 68;
        random_frames(500);
        // receiver holds off while the sender keeps offering
        hold_cycles = 400;
        random_frames(60);
        set_regs($urandom_range(261888), $urandom_range(261888),
                 $urandom, $urandom_range(32768), $urandom_range(32768));
        send_idle_pct = 68; recv_idle_pct = 34;
        random_frames(550);
        set_regs(300, 60000, 16777215, 32768, 0);
        send_idle_pct = 0; recv_idle_pct = 0;
        random_frames(650);

        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[dual_tap_sawtooth_flanger.f]
sv/dtsf_pkg.sv
sv/dtsf_ctrl.sv
sv/dtsf_dpath.sv
sv/dual_tap_sawtooth_flanger.sv
test/flanger_checker.sv
test/tb_dual_tap_sawtooth_flanger.sv
